FILE: rtl/ccse_pkg.sv
// ----------------------------------------------------------------------------
// ccse_pkg: shared definitions of the CRC / byte sum engine
// Register indexes, mode and width codes, bus widths and a bit reverse helper.
// ----------------------------------------------------------------------------
package ccse_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CALC_W     = 32;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_CHECK_MODE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_CODE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_POLY        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INIT_VALUE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_REFLECT_IN  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_REFLECT_OUT = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_XOR_OUT     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_EMIT_LE     = 3'd7;

    // Check mode codes.
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_SUM  = 2'd1;
    localparam logic [1:0] MODE_CRC  = 2'd2;

    // CRC width codes.
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [31:0] RST_POLY    = 32'h04C1_1DB7;
    localparam logic [31:0] RST_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_XOR_OUT = 32'hFFFF_FFFF;

    function automatic logic [CALC_W-1:0] bitrev32(input logic [CALC_W-1:0] v);
        logic [CALC_W-1:0] r;
        for (int i = 0; i < CALC_W; i++)
        begin
            r[i] = v[CALC_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] bitrev8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

endpackage

FILE: rtl/configurable_crc_sum_engine_unit.sv
// ----------------------------------------------------------------------------
// configurable_crc_sum_engine_unit: byte stream CRC / eight-bit sum engine
// Absorbs message bytes and emits a sum byte or a 1 to 4 byte CRC per message.
// ----------------------------------------------------------------------------
// Usage: message bytes enter on the slave stream (s_tdata is the byte, s_tlast
// marks the final byte of a message). Each byte is one transfer. Results leave
// on the master stream: at the end of a message the block sends the eight-bit
// sum as a single byte, or the finished CRC as width/8 bytes in the selected
// byte order, with m_tlast on the final byte of that run. In mode none nothing
// is sent, though bytes are still absorbed and message framing is kept.
// Configuration is written through cfg_we / cfg_addr / cfg_wdata while the
// block is idle; writes take effect at the next clock edge.
// Path: a byte is captured in the input register, is folded into the CRC
// and sum state in one pass of XOR logic, and any result byte is registered
// into the output buffer that drives m_tvalid, so the first result byte
// follows the last message byte through both of these registers.
// Throughput: one byte per cycle while the input register can advance; the
// eight-step CRC update is unrolled into combinational logic. A CRC run of
// N bytes holds the output buffer until all are taken; a later final byte
// waits in the input register until then, so short messages are limited by
// the result run length. Reset clears the input register and the output
// buffer, sets the message start flag, and loads the documented configuration
// defaults. When the receiver stalls, the output buffer holds its bytes;
// non-final input bytes keep flowing, and a final byte is held (s_tready
// drops) until the run ahead of it has been taken.
// ----------------------------------------------------------------------------
module configurable_crc_sum_engine_unit #(
    parameter int MAX_CRC_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Slave stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ccse_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] data_byte
    input  logic                                s_tlast,   // end_of_message
    // Master stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ccse_pkg::BYTE_W-1:0]         m_tdata,   // [7:0] check_byte
    output logic                                m_tlast,   // last_check_byte
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [ccse_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ccse_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Stored CRC width: the largest width the configuration can select.
    localparam int CRC_W  = (MAX_CRC_WIDTH >= 32) ? 32 : (MAX_CRC_WIDTH & ~7);
    localparam int CALC_W = ccse_pkg::CALC_W;
    localparam int BW     = ccse_pkg::BYTE_W;

    // Configuration registers.
    logic [1:0]        check_mode_reg;
    logic [1:0]        width_code_reg;
    logic [CALC_W-1:0] poly_reg;
    logic [CALC_W-1:0] init_value_reg;
    logic              reflect_in_reg;
    logic              reflect_out_reg;
    logic [CALC_W-1:0] xor_out_reg;
    logic              emit_le_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_mode_reg  <= ccse_pkg::MODE_SUM;
            width_code_reg  <= ccse_pkg::WIDTH_32;
            poly_reg        <= ccse_pkg::RST_POLY;
            init_value_reg  <= ccse_pkg::RST_INIT;
            reflect_in_reg  <= 1'b1;
            reflect_out_reg <= 1'b1;
            xor_out_reg     <= ccse_pkg::RST_XOR_OUT;
            emit_le_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                ccse_pkg::REG_CHECK_MODE:  check_mode_reg  <= cfg_wdata[1:0];
                ccse_pkg::REG_WIDTH_CODE:  width_code_reg  <= cfg_wdata[1:0];
                ccse_pkg::REG_POLY:        poly_reg        <= cfg_wdata;
                ccse_pkg::REG_INIT_VALUE:  init_value_reg  <= cfg_wdata;
                ccse_pkg::REG_REFLECT_IN:  reflect_in_reg  <= cfg_wdata[0];
                ccse_pkg::REG_REFLECT_OUT: reflect_out_reg <= cfg_wdata[0];
                ccse_pkg::REG_XOR_OUT:     xor_out_reg     <= cfg_wdata;
                ccse_pkg::REG_EMIT_LE:     emit_le_reg     <= cfg_wdata[0];
                default:                   ;
            endcase
        end
    end

    // Input register: one byte waiting to be folded into the state.
    logic          in_vld_reg;
    logic [BW-1:0] in_data_reg;
    logic          in_last_reg;

    // Message state.
    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [BW-1:0]    sum_reg;
    logic [BW-1:0]    sum_next;
    logic             at_start_reg;

    // Output buffer: up to four result bytes in send order, slot 0 on the bus.
    logic [BW-1:0] obuf_reg  [4];
    logic [BW-1:0] obuf_next [4];
    logic [2:0]    ocnt_reg;
    logic [2:0]    ocnt_next;

    logic in_emit;
    logic obuf_free;
    logic in_adv;

    assign in_emit   = in_last_reg && (check_mode_reg == ccse_pkg::MODE_SUM ||
                                       check_mode_reg == ccse_pkg::MODE_CRC);
    assign obuf_free = (ocnt_reg == 3'd0) || (ocnt_reg == 3'd1 && m_tready);
    assign in_adv    = in_vld_reg && (!in_emit || obuf_free);
    assign s_tready  = !in_vld_reg || in_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Effective CRC width, clipped to the stored width.
    logic [5:0] sel_w;
    logic [5:0] eff_w;
    logic [5:0] align_sh;
    logic [2:0] nbytes;

    always_comb
    begin
        unique case (width_code_reg)
            ccse_pkg::WIDTH_8:  sel_w = 6'd8;
            ccse_pkg::WIDTH_16: sel_w = 6'd16;
            default:            sel_w = 6'd32;
        endcase
        eff_w    = (sel_w > 6'(CRC_W)) ? 6'(CRC_W) : sel_w;
        align_sh = 6'(CALC_W) - eff_w;
        nbytes   = eff_w[5:3];
    end

    // One byte of MSB-first CRC, worked with the register aligned to bit 31 so
    // that every width shares the same shift and feedback logic.
    logic [CALC_W-1:0] mask;
    logic [CALC_W-1:0] crc_cur;
    logic [CALC_W-1:0] poly_al;
    logic [CALC_W-1:0] acc;
    logic [CALC_W-1:0] crc_new;
    logic [CALC_W-1:0] crc_fin;
    logic [BW-1:0]     din;
    logic [BW-1:0]     msg_byte[4];
    logic [2:0]        lo_idx;
    logic [1:0]        sel_idx;

    always_comb
    begin
        mask    = {CALC_W{1'b1}} >> align_sh;
        crc_cur = at_start_reg ? (init_value_reg & mask)
                               : (CALC_W'(crc_reg) & mask);
        poly_al = (poly_reg & mask) << align_sh;
        din     = reflect_in_reg ? ccse_pkg::bitrev8(in_data_reg) : in_data_reg;
        acc     = (crc_cur << align_sh) ^ {din, {(CALC_W-BW){1'b0}}};
        for (int i = 0; i < BW; i++)
        begin
            acc = acc[CALC_W-1] ? ((acc << 1) ^ poly_al) : (acc << 1);
        end
        crc_new  = acc >> align_sh;
        crc_next = crc_new[CRC_W-1:0];
        sum_next = (at_start_reg ? '0 : sum_reg) + in_data_reg;

        // Reversing the aligned value leaves the reflected CRC in the low bits.
        crc_fin = ((reflect_out_reg ? ccse_pkg::bitrev32(acc) : crc_new)
                   ^ xor_out_reg) & mask;

        for (int i = 0; i < 4; i++)
        begin
            lo_idx      = nbytes - 3'd1 - 3'(i);
            sel_idx     = emit_le_reg ? 2'(i) : lo_idx[1:0];
            msg_byte[i] = crc_fin[8*sel_idx +: BW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
        end
        else if (in_adv)
        begin
            at_start_reg <= in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv)
        begin
            crc_reg <= crc_next;
            sum_reg <= sum_next;
        end
    end

    // Output buffer control: a new run replaces the buffer only when it is
    // empty or its last byte goes out in this cycle; otherwise bytes shift when one is taken.
    always_comb
    begin
        ocnt_next = ocnt_reg;
        for (int i = 0; i < 4; i++)
        begin
            obuf_next[i] = obuf_reg[i];
        end
        if (in_adv && in_emit)
        begin
            if (check_mode_reg == ccse_pkg::MODE_SUM)
            begin
                obuf_next[0] = sum_next;
                ocnt_next    = 3'd1;
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    obuf_next[i] = msg_byte[i];
                end
                ocnt_next = nbytes;
            end
        end
        else if (m_tvalid && m_tready)
        begin
            for (int i = 0; i < 3; i++)
            begin
                obuf_next[i] = obuf_reg[i+1];
            end
            ocnt_next = ocnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= '0;
        end
        else
        begin
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            obuf_reg[i] <= obuf_next[i];
        end
    end

    assign m_tvalid = (ocnt_reg != 3'd0);
    assign m_tdata  = obuf_reg[0];
    assign m_tlast  = (ocnt_reg == 3'd1);

endmodule

FILE: rtl/ccse_checker.sv
// ----------------------------------------------------------------------------
// ccse_checker: port level checks of the CRC / byte sum engine
// Watches the stream ports and flags handshake and buffering slips.
// ----------------------------------------------------------------------------
module ccse_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [ccse_pkg::BYTE_W-1:0] m_tdata,
    input logic                        m_tlast
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("m_tdata or m_tlast changed while stalled");

    // With nothing left to send, the input side is always open.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with an empty output buffer");

    // The bytes of one run follow each other without a gap.
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a result run");

endmodule

bind configurable_crc_sum_engine_unit ccse_checker u_ccse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
